[rtl/tsc_pkg.sv]
// Shared types, constants and series coefficients for the sine, cosine and tangent unit.
package tsc_pkg;

	localparam int FRAC_BITS = 40;
	localparam int W = 48;
	localparam int Q32_SHIFT = FRAC_BITS - 32;
	localparam int ANGLE_SHIFT = FRAC_BITS - 28;
	localparam int DIV_BITS = 49;
	localparam int DIV_PRE = DIV_BITS - 32;
	localparam int N_SIN = 5;
	localparam int N_COS = 3;

	localparam logic [1:0] OP_SIN = 2'd0;
	localparam logic [1:0] OP_COS = 2'd1;
	localparam logic [1:0] OP_TAN = 2'd2;

	localparam logic [63:0] PI_Q60 = 64'h3243_F6A8_885A_308D;
	localparam logic signed [W-1:0] PI_Q =
		W'((PI_Q60 + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS));
	localparam logic signed [W-1:0] TWO_PI_Q =
		W'((PI_Q60 + (64'd1 << (58 - FRAC_BITS))) >> (59 - FRAC_BITS));
	localparam logic signed [W-1:0] ONE_Q = W'(64'd1 << FRAC_BITS);

	localparam logic [W-1:0] R_SIN [N_SIN] = '{
		W'(((64'd1 << FRAC_BITS) + 64'd3) / 64'd6),
		W'(((64'd1 << FRAC_BITS) + 64'd10) / 64'd20),
		W'(((64'd1 << FRAC_BITS) + 64'd21) / 64'd42),
		W'(((64'd1 << FRAC_BITS) + 64'd36) / 64'd72),
		W'(((64'd1 << FRAC_BITS) + 64'd55) / 64'd110)
	};
	localparam logic [W-1:0] R_COS [N_COS] = '{
		W'(((64'd1 << FRAC_BITS) + 64'd1) / 64'd2),
		W'(((64'd1 << FRAC_BITS) + 64'd6) / 64'd12),
		W'(((64'd1 << FRAC_BITS) + 64'd15) / 64'd30)
	};

	localparam logic signed [W-1:0] OUT_MAX = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [W-1:0] OUT_MIN = 48'sh8000_0000_0000;

	typedef struct packed {
		logic [1:0] op;
		logic signed [31:0] angle;
	} in_item_t;

	typedef struct packed {
		logic signed [47:0] result;
		logic saturated;
	} out_item_t;

	typedef struct packed {
		logic [1:0] op;
		logic apos;
		logic pole;
		logic neg;
		logic big;
		logic signed [W-1:0] sc;
	} side_t;

endpackage

[rtl/taylor_sine_cosine_tangent_unit.sv]
// Top level of the pipelined sine, cosine and tangent unit.
// The input channel (in_valid, in_ready, in_data) takes one beat per item: an op
// (sine, cosine or tangent) and a signed Q3.28 angle. The output channel (out_valid,
// out_ready, out_data) returns one beat per item: a signed Q15.32 result and a flag
// that marks a clipped result or a tangent pole. Results leave in input order.
// The configuration channel (cfg_valid, cfg_ready, cfg_data) writes the tangent pole
// threshold; it is always ready and should be written only while the pipeline is empty.
// Between an accepted beat and its output beat lie one stage of angle reduction, two
// per multiply along the sine chain of seven multiplies, one stage for the last addition
// of the sum, one stage to set up the tangent, 49 divider stages at one quotient bit
// each, and the output register. Throughput is one item per cycle while not stalled.
// When the receiver stalls, the whole pipeline holds and in_ready drops only while the
// output register holds a beat that is not taken; nothing is lost or repeated.
// Reset clears all valid bits and sets the pole threshold to one.
module taylor_sine_cosine_tangent_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  tsc_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output tsc_pkg::out_item_t  out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [32:0]         cfg_data
);

	localparam int W = tsc_pkg::W;
	localparam int STAGES = 67;
	localparam int PRE_DLY = 15;

	logic en;
	logic [STAGES-1:0] vld_q;
	logic [32:0] thr_q;

	logic signed [W-1:0] xw;
	logic signed [W-1:0] xr;
	logic [1:0] op_s1;
	logic apos_s1;
	logic signed [W-1:0] x_s1;
	logic signed [W-1:0] x2_s3;
	logic [W-1:0] x_s5;
	logic [W-1:0] msin [tsc_pkg::N_SIN];
	logic [W-1:0] mcos [tsc_pkg::N_COS];
	logic signed [W-1:0] sin_s16;
	logic signed [W-1:0] cos_s12;
	logic [W-1:0] cos_s16;
	logic [2:0] pre_s16;

	logic signed [W-1:0] sv;
	logic signed [W-1:0] cv;
	logic [W-1:0] sm;
	logic [W-1:0] cm;
	tsc_pkg::side_t side_n;
	tsc_pkg::side_t side_s17;
	logic [W-1:0] sm_s17;
	logic [W-1:0] cm_s17;
	logic [W-1:0] rem_s17;
	logic [tsc_pkg::DIV_BITS-1:0] q_s66;
	logic [$bits(tsc_pkg::side_t)-1:0] side_w66;
	tsc_pkg::side_t side_s66;
	tsc_pkg::out_item_t res_n;

	function automatic logic signed [W-1:0] to_q32(input logic signed [W-1:0] v);
		logic [W-1:0] mv;
		mv = v[W-1] ? W'(-v) : W'(v);
		mv = mv >> tsc_pkg::Q32_SHIFT;
		return v[W-1] ? W'(-mv) : mv;
	endfunction

	assign en = !vld_q[STAGES-1] || out_ready;
	assign in_ready = en;
	assign out_valid = vld_q[STAGES-1];
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[STAGES-2:0], in_valid};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= 33'd1;
		end else if (cfg_valid && cfg_ready) begin
			thr_q <= cfg_data;
		end
	end

	// Widen the angle and fold it into the range minus pi to pi.
	assign xw = {{(W - 32 - tsc_pkg::ANGLE_SHIFT){in_data.angle[31]}}, in_data.angle,
		{tsc_pkg::ANGLE_SHIFT{1'b0}}};

	always_comb begin
		if (xw > tsc_pkg::PI_Q) begin
			xr = xw - tsc_pkg::TWO_PI_Q;
		end else if (xw < -tsc_pkg::PI_Q) begin
			xr = xw + tsc_pkg::TWO_PI_Q;
		end else begin
			xr = xw;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1   <= in_data.op;
			apos_s1 <= !in_data.angle[31] && (in_data.angle != '0);
			x_s1    <= xr;
		end
	end

	tsc_mul u_x2 (
		.clk(clk), .en(en), .a(x_s1), .b(x_s1), .negate(1'b0), .p(x2_s3)
	);

	tsc_dly #(.W(W), .N(4)) u_xdly (
		.clk(clk), .en(en), .d(x_s1), .q(x_s5)
	);

	for (genvar k = 0; k < tsc_pkg::N_SIN; k++) begin : g_msin
		logic signed [W-1:0] p;
		tsc_mul u_m (
			.clk(clk), .en(en), .a(x2_s3), .b(signed'(tsc_pkg::R_SIN[k])),
			.negate(1'b0), .p(p)
		);
		assign msin[k] = p;
	end

	for (genvar k = 0; k < tsc_pkg::N_COS; k++) begin : g_mcos
		logic signed [W-1:0] p;
		tsc_mul u_m (
			.clk(clk), .en(en), .a(x2_s3), .b(signed'(tsc_pkg::R_COS[k])),
			.negate(1'b0), .p(p)
		);
		assign mcos[k] = p;
	end

	tsc_series #(.N(tsc_pkg::N_SIN)) u_sin (
		.clk(clk), .en(en), .first(signed'(x_s5)), .m(msin), .sum(sin_s16)
	);

	tsc_series #(.N(tsc_pkg::N_COS)) u_cos (
		.clk(clk), .en(en), .first(tsc_pkg::ONE_Q), .m(mcos), .sum(cos_s12)
	);

	tsc_dly #(.W(W), .N(2 * (tsc_pkg::N_SIN - tsc_pkg::N_COS))) u_cdly (
		.clk(clk), .en(en), .d(cos_s12), .q(cos_s16)
	);

	tsc_dly #(.W(3), .N(PRE_DLY)) u_pdly (
		.clk(clk), .en(en), .d({op_s1, apos_s1}), .q(pre_s16)
	);

	// Tangent setup: magnitudes, pole test and the quotient's high bits.
	assign sv = sin_s16;
	assign cv = signed'(cos_s16);
	assign sm = sv[W-1] ? W'(-sv) : W'(sv);
	assign cm = cv[W-1] ? W'(-cv) : W'(cv);

	always_comb begin
		side_n.op   = pre_s16[2:1];
		side_n.apos = pre_s16[0];
		side_n.pole = (cm == '0) || ((cm >> tsc_pkg::Q32_SHIFT) < W'(thr_q));
		side_n.neg  = sv[W-1] ^ cv[W-1];
		side_n.big  = (sm >> tsc_pkg::DIV_PRE) >= cm;
		side_n.sc   = (pre_s16[2:1] == tsc_pkg::OP_COS) ? to_q32(cv) : to_q32(sv);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s17 <= side_n;
			sm_s17   <= sm;
			cm_s17   <= cm;
			rem_s17  <= sm >> tsc_pkg::DIV_PRE;
		end
	end

	tsc_div u_div (
		.clk(clk), .en(en), .sm(sm_s17), .cm(cm_s17), .rem0(rem_s17), .q(q_s66)
	);

	tsc_dly #(.W($bits(tsc_pkg::side_t)), .N(tsc_pkg::DIV_BITS)) u_sdly (
		.clk(clk), .en(en), .d(side_s17), .q(side_w66)
	);

	assign side_s66 = side_w66;

	always_comb begin
		res_n.result = '0;
		res_n.saturated = 1'b0;
		case (side_s66.op) inside
			tsc_pkg::OP_SIN, tsc_pkg::OP_COS: begin
				res_n.result = side_s66.sc;
			end
			tsc_pkg::OP_TAN: begin
				if (side_s66.pole) begin
					res_n.saturated = 1'b1;
					res_n.result = side_s66.apos ? tsc_pkg::OUT_MAX : tsc_pkg::OUT_MIN;
				end else if (side_s66.neg) begin
					if (side_s66.big || (q_s66 > (tsc_pkg::DIV_BITS)'(49'h1 << 47))) begin
						res_n.saturated = 1'b1;
						res_n.result = tsc_pkg::OUT_MIN;
					end else begin
						res_n.result = W'(-q_s66);
					end
				end else begin
					if (side_s66.big || (q_s66 > (tsc_pkg::DIV_BITS)'(tsc_pkg::OUT_MAX))) begin
						res_n.saturated = 1'b1;
						res_n.result = tsc_pkg::OUT_MAX;
					end else begin
						res_n.result = q_s66[W-1:0];
					end
				end
			end
			default: begin
				res_n.result = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data <= res_n;
		end
	end

endmodule

[rtl/tsc_dly.sv]
// Enabled shift line that delays a word by a fixed number of pipeline stages.
module tsc_dly #(
	parameter int W = 1,
	parameter int N = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] sr_q [N];

	always_ff @(posedge clk) begin
		if (en) begin
			sr_q[0] <= d;
			for (int i = 1; i < N; i++) begin
				sr_q[i] <= sr_q[i-1];
			end
		end
	end

	assign q = sr_q[N-1];

endmodule

[rtl/tsc_mul.sv]
// Two-stage signed fixed-point multiplier, truncating toward zero, from partial products of 24-bit halves.
module tsc_mul (
	input  logic                           clk,
	input  logic                           en,
	input  logic signed [tsc_pkg::W-1:0]   a,
	input  logic signed [tsc_pkg::W-1:0]   b,
	input  logic                           negate,
	output logic signed [tsc_pkg::W-1:0]   p
);

	localparam int H = tsc_pkg::W / 2;

	logic [tsc_pkg::W-1:0] ma;
	logic [tsc_pkg::W-1:0] mb;
	logic [tsc_pkg::W-1:0] p00_s1;
	logic [tsc_pkg::W-1:0] p01_s1;
	logic [tsc_pkg::W-1:0] p10_s1;
	logic [tsc_pkg::W-1:0] p11_s1;
	logic neg_s1;
	logic [2*tsc_pkg::W-1:0] full;
	logic [tsc_pkg::W-1:0] m;

	assign ma = a[tsc_pkg::W-1] ? tsc_pkg::W'(-a) : tsc_pkg::W'(a);
	assign mb = b[tsc_pkg::W-1] ? tsc_pkg::W'(-b) : tsc_pkg::W'(b);

	always_ff @(posedge clk) begin
		if (en) begin
			p00_s1 <= ma[H-1:0] * mb[H-1:0];
			p01_s1 <= ma[H-1:0] * mb[tsc_pkg::W-1:H];
			p10_s1 <= ma[tsc_pkg::W-1:H] * mb[H-1:0];
			p11_s1 <= ma[tsc_pkg::W-1:H] * mb[tsc_pkg::W-1:H];
			neg_s1 <= a[tsc_pkg::W-1] ^ b[tsc_pkg::W-1] ^ negate;
		end
	end

	assign full = (2*tsc_pkg::W)'(p00_s1)
		+ ((2*tsc_pkg::W)'(p01_s1) << H)
		+ ((2*tsc_pkg::W)'(p10_s1) << H)
		+ ((2*tsc_pkg::W)'(p11_s1) << tsc_pkg::W);
	assign m = full[tsc_pkg::FRAC_BITS +: tsc_pkg::W];

	always_ff @(posedge clk) begin
		if (en) begin
			p <= neg_s1 ? tsc_pkg::W'(-m) : m;
		end
	end

endmodule

[rtl/tsc_series.sv]
// Pipelined Taylor series: one term multiply per two stages, running sum kept beside it.
module tsc_series #(
	parameter int N = 3
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic signed [tsc_pkg::W-1:0] first,
	input  logic [tsc_pkg::W-1:0]        m [N],
	output logic signed [tsc_pkg::W-1:0] sum
);

	logic signed [tsc_pkg::W-1:0] term [N+1];
	logic signed [tsc_pkg::W-1:0] acc_s [N+1];

	assign term[0] = first;

	always_ff @(posedge clk) begin
		if (en) begin
			acc_s[0] <= term[0];
		end
	end

	for (genvar k = 1; k <= N; k++) begin : g_step
		logic [tsc_pkg::W-1:0] mk;
		logic [tsc_pkg::W-1:0] acc_d;

		if (k == 1) begin : g_first
			assign mk = m[0];
		end else begin : g_later
			tsc_dly #(.W(tsc_pkg::W), .N(2*(k-1))) u_mdly (
				.clk(clk), .en(en), .d(m[k-1]), .q(mk)
			);
		end

		tsc_mul u_mul (
			.clk(clk), .en(en), .a(term[k-1]), .b(signed'(mk)),
			.negate(1'b1), .p(term[k])
		);

		tsc_dly #(.W(tsc_pkg::W), .N(1)) u_adly (
			.clk(clk), .en(en), .d(acc_s[k-1]), .q(acc_d)
		);

		always_ff @(posedge clk) begin
			if (en) begin
				acc_s[k] <= signed'(acc_d) + term[k];
			end
		end
	end

	assign sum = acc_s[N];

endmodule

[rtl/tsc_div.sv]
// Pipelined restoring divider: one quotient bit per stage of the tangent quotient.
module tsc_div (
	input  logic                          clk,
	input  logic                          en,
	input  logic [tsc_pkg::W-1:0]         sm,
	input  logic [tsc_pkg::W-1:0]         cm,
	input  logic [tsc_pkg::W-1:0]         rem0,
	output logic [tsc_pkg::DIV_BITS-1:0]  q
);

	localparam int NB = tsc_pkg::DIV_BITS;

	logic [tsc_pkg::W-1:0] rem_s [NB+1];
	logic [NB-1:0]         q_s   [NB+1];
	logic [tsc_pkg::W-1:0] sm_s  [NB+1];
	logic [tsc_pkg::W-1:0] cm_s  [NB+1];

	assign rem_s[0] = rem0;
	assign q_s[0]   = '0;
	assign sm_s[0]  = sm;
	assign cm_s[0]  = cm;

	for (genvar i = 0; i < NB; i++) begin : g_stage
		localparam int B = NB - 1 - i;
		logic bitv;
		logic [tsc_pkg::W:0] trial;
		logic ge;

		if (B >= 32) begin : g_data
			assign bitv = sm_s[i][B-32];
		end else begin : g_zero
			assign bitv = 1'b0;
		end

		assign trial = {rem_s[i], bitv};
		assign ge = trial >= {1'b0, cm_s[i]};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= ge ? tsc_pkg::W'(trial - {1'b0, cm_s[i]})
				                 : trial[tsc_pkg::W-1:0];
				q_s[i+1]   <= {q_s[i][NB-2:0], ge};
				sm_s[i+1]  <= sm_s[i];
				cm_s[i+1]  <= cm_s[i];
			end
		end
	end

	assign q = q_s[NB];

endmodule

[rtl/tsc_checker.sv]
// Port-level checker for the sine, cosine and tangent unit, bound to the top level.
module tsc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input tsc_pkg::in_item_t  in_data,
	input logic               out_valid,
	input logic               out_ready,
	input tsc_pkg::out_item_t out_data,
	input logic               cfg_valid,
	input logic               cfg_ready,
	input logic [32:0]        cfg_data
);

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output beat changed while stalled");

	a_ready_flow: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready does not follow the output register");

	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.saturated |->
			(out_data.result == tsc_pkg::OUT_MAX) || (out_data.result == tsc_pkg::OUT_MIN))
		else $error("saturated beat without a full-scale result");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration channel not ready");

endmodule

bind taylor_sine_cosine_tangent_unit tsc_checker u_tsc_checker (.*);

[bench/taylor_sine_cosine_tangent_unit_check.sv]
// Checker that predicts every result of the sine, cosine and tangent unit and compares it.
module taylor_sine_cosine_tangent_unit_check (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  tsc_pkg::in_item_t   in_data,
	input  logic                out_valid,
	input  logic                out_ready,
	input  tsc_pkg::out_item_t  out_data,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic [32:0]         cfg_data,
	output int                  fail_count,
	output int                  pending
);
	import tsc_pkg::*;

	localparam int FB = 40;
	localparam logic [63:0] PI_WORD = 64'h3243F6A8885A308D;

	logic [32:0] pole_limit;
	out_item_t trig_queue[$];

	function automatic logic signed [63:0] qmul(logic signed [63:0] a, logic signed [63:0] b);
		logic [63:0] x;
		logic [63:0] y;
		logic [127:0] p;
		logic [63:0] m;
		x = a < 0 ? -a : a;
		y = b < 0 ? -b : b;
		p = x * y;
		m = p[FB +: 64];
		return ((a < 0) != (b < 0)) ? -$signed(m) : $signed(m);
	endfunction

	function automatic logic signed [63:0] recip_of(logic [63:0] d);
		return ((64'd1 << FB) + d / 2) / d;
	endfunction

	function automatic logic signed [63:0] q40_to_q32(logic signed [63:0] v);
		return v / (64'sd1 << (FB - 32));
	endfunction

	function automatic out_item_t predict_trig(in_item_t it);
		logic signed [63:0] pi_q;
		logic signed [63:0] two_pi;
		logic signed [63:0] x;
		logic signed [63:0] x2;
		logic signed [63:0] term;
		logic signed [63:0] s;
		logic signed [63:0] c;
		logic signed [63:0] res;
		logic [63:0] cm;
		logic [63:0] sm;
		logic [63:0] cq;
		logic [127:0] quo;
		logic [63:0] sin_den[5];
		logic [63:0] cos_den[3];
		logic sat;
		out_item_t o;
		sin_den = '{6, 20, 42, 72, 110};
		cos_den = '{2, 12, 30};
		pi_q = (PI_WORD + (64'd1 << (59 - FB))) >> (60 - FB);
		two_pi = (PI_WORD + (64'd1 << (58 - FB))) >> (59 - FB);
		x = 64'(it.angle) <<< (FB - 28);
		if (x > pi_q) x = x - two_pi;
		else if (x < -pi_q) x = x + two_pi;
		x2 = qmul(x, x);
		term = x;
		s = x;
		for (int i = 0; i < 5; i++) begin
			term = qmul(term, -qmul(x2, recip_of(sin_den[i])));
			s = s + term;
		end
		term = 64'sd1 <<< FB;
		c = term;
		for (int i = 0; i < 3; i++) begin
			term = qmul(term, -qmul(x2, recip_of(cos_den[i])));
			c = c + term;
		end
		res = 0;
		sat = 0;
		case (it.op)
			OP_SIN: res = q40_to_q32(s);
			OP_COS: res = q40_to_q32(c);
			OP_TAN: begin
				cm = c < 0 ? -c : c;
				sm = s < 0 ? -s : s;
				cq = cm >> (FB - 32);
				if (cm == 0 || {31'd0, cq} < {62'd0, pole_limit}) begin
					sat = 1;
					res = it.angle > 0 ? 64'sh7FFFFFFFFFFF : -64'sh800000000000;
				end else begin
					quo = {sm, 32'd0} / cm;
					if ((s < 0) != (c < 0)) begin
						if (quo > 128'h800000000000) begin
							sat = 1;
							res = -64'sh800000000000;
						end else res = -$signed(quo[63:0]);
					end else begin
						if (quo > 128'h7FFFFFFFFFFF) begin
							sat = 1;
							res = 64'sh7FFFFFFFFFFF;
						end else res = quo[63:0];
					end
				end
			end
			default: ;
		endcase
		o.result = res[47:0];
		o.saturated = sat;
		return o;
	endfunction

	assign pending = trig_queue.size();

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			pole_limit <= 33'd1;
			fail_count <= 0;
			trig_queue.delete();
		end else begin
			if (in_valid && in_ready) trig_queue.push_back(predict_trig(in_data));
			if (out_valid && out_ready) begin
				if (trig_queue.size() == 0) begin
					$display("%0t: unexpected beat, actual %h", $time, out_data);
					fail_count <= fail_count + 1;
				end else begin
					want = trig_queue.pop_front();
					if (want.result !== out_data.result) begin
						$display("%0t: result expected %h actual %h", $time,
							want.result, out_data.result);
						fail_count <= fail_count + 1;
					end else if (want.saturated !== out_data.saturated) begin
						$display("%0t: saturated expected %b actual %b", $time,
							want.saturated, out_data.saturated);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (cfg_valid && cfg_ready) pole_limit <= cfg_data;
		end
	end
endmodule

[bench/taylor_sine_cosine_tangent_unit_test.sv]
// Testbench top: stimulus, pole threshold phases and the final verdict for the trig unit.
module taylor_sine_cosine_tangent_unit_test;
	import tsc_pkg::*;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_item_t in_data;
	logic out_valid;
	logic out_ready;
	out_item_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [32:0] cfg_data;
	int fail_count;
	int pending;
	int cycles;
	int hold_off;
	logic press;
	logic long_hold;

	taylor_sine_cosine_tangent_unit uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	taylor_sine_cosine_tangent_unit_check check (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	function automatic int gap_len();
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
		if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
		return 0;
	endfunction

	task automatic send_beat(logic [1:0] op, logic [31:0] angle);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1;
		in_data <= '{op: op, angle: angle};
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic write_limit(logic [32:0] v);
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		cfg_valid <= 1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 0;
	endtask

	task automatic random_run(int n);
		logic [31:0] a;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 5))
				0: a = $urandom;
				1: a = $urandom_range(0, 32'h10000) + 32'h1921FB54 - 32'h8000;
				2: a = -($urandom_range(0, 32'h10000) + 32'h1921FB54 - 32'h8000);
				3: a = $urandom_range(0, 32'h3FFF) - 32'h2000;
				default: a = $urandom_range(0, 32'h6487ED51 * 2) - 32'h6487ED51;
			endcase
			send_beat($urandom_range(0, 9) == 0 ? 2'd3 : 2'($urandom_range(0, 2)), a);
		end
	endtask

	initial begin
		out_ready = 0;
		hold_off = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (long_hold) begin
				out_ready <= 0;
			end else if (hold_off > 0) begin
				hold_off <= hold_off - 1;
				out_ready <= 0;
			end else if ($urandom_range(0, 399) == 0) begin
				hold_off <= 300;
				out_ready <= 0;
			end else if ($urandom_range(0, 24) == 0) begin
				hold_off <= $urandom_range(5, 40);
				out_ready <= 0;
			end else out_ready <= $urandom_range(0, 3) != 0;
		end
	end

	initial begin
		long_hold = 0;
		wait (press);
		@(posedge clk);
		long_hold <= 1;
		repeat (250) @(posedge clk);
		long_hold <= 0;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 400000) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		logic [31:0] edge_angle[10];
		edge_angle = '{32'h80000000, 32'h7FFFFFFF, 0, 1, 32'hFFFFFFFF, 32'h3243F6A9,
			32'hCDBC0957, 32'h1921FB54, 32'hE6DE04AC, 32'h10000000};
		arst_n = 0;
		press = 0;
		in_valid = 0;
		in_data = '0;
		cfg_valid = 0;
		cfg_data = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		for (int i = 0; i < 10; i++)
			for (int k = 0; k < 2; k++) send_beat(k ? OP_TAN : 2'(i % 2), edge_angle[i]);
		send_beat(2'd3, 32'h12345678);
		send_beat(OP_SIN, 32'h12345678);
		// Receiver stalls long while the sender keeps pushing beats.
		press <= 1;
		for (int i = 0; i < 120; i++) send_beat(2'($urandom_range(0, 2)), $urandom);
		random_run(200);
		write_limit(33'd0);
		send_beat(OP_TAN, 32'h1921FB54);
		random_run(200);
		write_limit(33'h100000000);
		random_run(150);
		write_limit(33'h1FFFFFFFF);
		random_run(100);
		write_limit(33'd4096);
		random_run(160);
		write_limit(33'h00100000);
		random_run(100);
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0) $display("All tests passed");
		else $display("Some tests failed");
		$finish;
	end
endmodule
